### rtl/rth_pkg.sv
// rth_pkg: shared types and constants for the RGB to HSL converter.
// No dependencies; used by the interfaces, rgb_to_hsl and the bench.
package rth_pkg;

	localparam int CH_W     = 8;
	localparam int SUM_W    = 9;
	localparam int HUE_W    = 15;
	localparam int SAT_W    = 12;
	localparam int QUO_W    = 12;
	localparam int HUE_NUM_W = CH_W + QUO_W;
	localparam int SAT_DEN_W = CH_W + 1;
	localparam int SAT_NUM_W = SAT_DEN_W + QUO_W;

	localparam logic [HUE_W-1:0] HUE_SECTOR_Q6 = 15'd3840;
	localparam logic [HUE_W-1:0] HUE_GREEN_Q6  = 15'd7680;
	localparam logic [HUE_W-1:0] HUE_BLUE_Q6   = 15'd15360;
	localparam logic [HUE_W-1:0] HUE_FULL_Q6   = 15'd23040;
	localparam logic [SAT_NUM_W-1:0] SAT_SCALE2 = 21'd8190;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [HUE_W-1:0] hue_q6;
		logic [SAT_W-1:0] saturation_q12;
		logic [SUM_W-1:0] lightness_sum;
		logic             achromatic;
	} hsl_t;

	// side info that rides along the divider stages
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             grey;
		logic [HUE_W-1:0] base;
		logic             neg;
	} side_t;

endpackage

### rtl/rth_if.sv
// rth_rgb_if / rth_hsl_if: valid/ready channels carrying one word each.
// Depends on rth_pkg for the payload types.
interface rth_rgb_if;
	logic         valid;
	logic         ready;
	rth_pkg::rgb_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rth_hsl_if;
	logic         valid;
	logic         ready;
	rth_pkg::hsl_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/rth_div.sv
// rth_div: pipelined restoring divider, STEP quotient bits per stage.
// Needs dividend >> QUO_W below the divisor. No package dependency.
module rth_div #(
	parameter int DEN_W = 8,
	parameter int QUO_W = 12,
	parameter int STEP  = 3,
	localparam int NUM_W  = DEN_W + QUO_W,
	localparam int STAGES = (QUO_W + STEP - 1) / STEP
) (
	input  logic              clk,
	input  logic [STAGES-1:0] ld,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  dvs,
	output logic [QUO_W-1:0]  quo,
	output logic              rem_nz
);

	logic [DEN_W-1:0] rem_s [STAGES];
	logic [QUO_W-1:0] lo_s  [STAGES];
	logic [QUO_W-1:0] quo_s [STAGES];
	logic [DEN_W-1:0] dvs_s [STAGES];

	for (genvar s = 0; s < STAGES; s++) begin : g_st
		logic [DEN_W-1:0] rem_i, rem_o, dvs_i;
		logic [QUO_W-1:0] lo_i, lo_o, quo_i, quo_o;

		if (s == 0) begin : g_first
			assign rem_i = num[NUM_W-1:QUO_W];
			assign lo_i  = num[QUO_W-1:0];
			assign quo_i = '0;
			assign dvs_i = dvs;
		end else begin : g_next
			assign rem_i = rem_s[s-1];
			assign lo_i  = lo_s[s-1];
			assign quo_i = quo_s[s-1];
			assign dvs_i = dvs_s[s-1];
		end

		always_comb begin
			logic [DEN_W:0] t;
			t     = '0;
			rem_o = rem_i;
			lo_o  = lo_i;
			quo_o = quo_i;
			for (int j = 0; j < STEP; j++) begin
				if (s * STEP + j < QUO_W) begin
					t    = {rem_o, lo_o[QUO_W-1]};
					lo_o = {lo_o[QUO_W-2:0], 1'b0};
					if (t >= {1'b0, dvs_i}) begin
						rem_o = DEN_W'(t - {1'b0, dvs_i});
						quo_o = {quo_o[QUO_W-2:0], 1'b1};
					end else begin
						rem_o = t[DEN_W-1:0];
						quo_o = {quo_o[QUO_W-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (ld[s]) begin
				rem_s[s] <= rem_o;
				lo_s[s]  <= lo_o;
				quo_s[s] <= quo_o;
				dvs_s[s] <= dvs_i;
			end
		end
	end

	assign quo    = quo_s[STAGES-1];
	assign rem_nz = |rem_s[STAGES-1];

endmodule

### rtl/rgb_to_hsl.sv
// rgb_to_hsl: RGB pixel to hue / saturation / lightness, one word per clock unless stalled.
// Registered stages in order: min/max, numerator
// scaling, the divider stages (DIV_STEP quotient bits each), output stage.
// Throughput one word per cycle; a stalled output holds, empty stages still fill.
// arst_n clears all stage valid bits; data registers are not reset.
// Depends on rth_pkg, rth_if, rth_div.
module rgb_to_hsl #(
	parameter int DIV_STEP = 3
) (
	input logic        clk,
	input logic        arst_n,
	rth_rgb_if.sink    pix_in,
	rth_hsl_if.source  hsl_out
);

	localparam int DIV_STAGES = (rth_pkg::QUO_W + DIV_STEP - 1) / DIV_STEP;
	localparam int NST        = DIV_STAGES + 3;

	logic [NST-1:0] vld_q;
	logic [NST:0]   ld;

	always_comb begin
		ld[NST] = hsl_out.ready;
		for (int i = NST - 1; i >= 0; i--) begin
			ld[i] = !vld_q[i] || ld[i+1];
		end
	end

	assign pix_in.ready = ld[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[0]) begin
				vld_q[0] <= pix_in.valid;
			end
			for (int i = 1; i < NST; i++) begin
				if (ld[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	// stage 1: extremes, sector, hue offset
	logic [rth_pkg::CH_W-1:0] r, g, b, mx, mn, nabs;
	logic [rth_pkg::SUM_W-1:0] sum;
	logic [rth_pkg::CH_W-1:0] den;
	rth_pkg::side_t sb;

	assign r = pix_in.data.red;
	assign g = pix_in.data.green;
	assign b = pix_in.data.blue;

	always_comb begin
		mx  = (r >= g) ? ((r >= b) ? r : b) : ((g >= b) ? g : b);
		mn  = (r <= g) ? ((r <= b) ? r : b) : ((g <= b) ? g : b);
		sum = {1'b0, mx} + {1'b0, mn};
		den = sum[rth_pkg::CH_W] ? rth_pkg::CH_W'(9'd510 - sum) : sum[rth_pkg::CH_W-1:0];
		sb.sum  = sum;
		sb.grey = (mx == mn);
		if (mx == r) begin
			sb.neg  = g < b;
			nabs    = sb.neg ? b - g : g - b;
			sb.base = sb.neg ? rth_pkg::HUE_FULL_Q6 : '0;
		end else if (mx == g) begin
			sb.neg  = b < r;
			nabs    = sb.neg ? r - b : b - r;
			sb.base = rth_pkg::HUE_GREEN_Q6;
		end else begin
			sb.neg  = r < g;
			nabs    = sb.neg ? g - r : r - g;
			sb.base = rth_pkg::HUE_BLUE_Q6;
		end
	end

	logic [rth_pkg::CH_W-1:0] d_s1, den_s1, nabs_s1;
	rth_pkg::side_t sb_s1;

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			d_s1    <= mx - mn;
			den_s1  <= den;
			nabs_s1 <= nabs;
			sb_s1   <= sb;
		end
	end

	// stage 2: divider operands
	logic [rth_pkg::HUE_NUM_W-1:0] hue_num_s2;
	logic [rth_pkg::CH_W-1:0]      hue_dvs_s2;
	logic [rth_pkg::SAT_NUM_W-1:0] sat_num_s2;
	logic [rth_pkg::SAT_DEN_W-1:0] sat_dvs_s2;
	rth_pkg::side_t sb_s2;

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			hue_num_s2 <= rth_pkg::HUE_NUM_W'(nabs_s1)
				* rth_pkg::HUE_NUM_W'(rth_pkg::HUE_SECTOR_Q6);
			hue_dvs_s2 <= d_s1;
			sat_num_s2 <= rth_pkg::SAT_NUM_W'(d_s1) * rth_pkg::SAT_SCALE2
				+ rth_pkg::SAT_NUM_W'(den_s1);
			sat_dvs_s2 <= {den_s1, 1'b0};
			sb_s2      <= sb_s1;
		end
	end

	// divider stages
	logic [rth_pkg::QUO_W-1:0] hue_quo, sat_quo;
	logic                      hue_rnz, sat_rnz;

	rth_div #(
		.DEN_W (rth_pkg::CH_W),
		.QUO_W (rth_pkg::QUO_W),
		.STEP  (DIV_STEP)
	) u_hue_div (
		.clk    (clk),
		.ld     (ld[NST-2:2]),
		.num    (hue_num_s2),
		.dvs    (hue_dvs_s2),
		.quo    (hue_quo),
		.rem_nz (hue_rnz)
	);

	rth_div #(
		.DEN_W (rth_pkg::SAT_DEN_W),
		.QUO_W (rth_pkg::QUO_W),
		.STEP  (DIV_STEP)
	) u_sat_div (
		.clk    (clk),
		.ld     (ld[NST-2:2]),
		.num    (sat_num_s2),
		.dvs    (sat_dvs_s2),
		.quo    (sat_quo),
		.rem_nz (sat_rnz)
	);

	// side info, one entry per divider stage
	rth_pkg::side_t sb_s3 [DIV_STAGES];

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			sb_s3[0] <= sb_s2;
		end
		for (int k = 1; k < DIV_STAGES; k++) begin
			if (ld[k+2]) begin
				sb_s3[k] <= sb_s3[k-1];
			end
		end
	end

	// output stage: negative offsets round toward the lower hue
	rth_pkg::side_t sb_o;
	rth_pkg::hsl_t  res;
	rth_pkg::hsl_t  res_q;

	assign sb_o = sb_s3[DIV_STAGES-1];

	always_comb begin
		res.lightness_sum = sb_o.sum;
		res.achromatic    = sb_o.grey;
		if (sb_o.grey) begin
			res.hue_q6         = '0;
			res.saturation_q12 = '0;
		end else begin
			res.saturation_q12 = sat_quo;
			if (sb_o.neg) begin
				res.hue_q6 = sb_o.base - rth_pkg::HUE_W'(hue_quo)
					- rth_pkg::HUE_W'(hue_rnz);
			end else begin
				res.hue_q6 = sb_o.base + rth_pkg::HUE_W'(hue_quo);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld[NST-1]) begin
			res_q <= res;
		end
	end

	assign hsl_out.valid = vld_q[NST-1];
	assign hsl_out.data  = res_q;

	logic unused_sat_rnz;
	assign unused_sat_rnz = sat_rnz;

endmodule

### sim/tb_rgb_to_hsl.sv
// tb_rgb_to_hsl: self-checking bench for the RGB to HSL pixel converter.
// Streams directed and random pixels and checks every HSL word against a predictor.
// Depends on rth_pkg, rth_if and the rgb_to_hsl RTL.
`timescale 1ns / 100ps

module tb_rgb_to_hsl;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int          DRAIN_CYCLES = 20;

	class hsl_scoreboard;
		rth_pkg::hsl_t expected_q[$];
		int   errors;

		function rth_pkg::hsl_t convert(rth_pkg::rgb_t px);
			rth_pkg::hsl_t res;
			int r, g, b, mx, mn, d, sum, den, k, n, num, sat, hue;
			r = px.red;
			g = px.green;
			b = px.blue;
			mx = (r > g) ? r : g;
			mx = (mx > b) ? mx : b;
			mn = (r < g) ? r : g;
			mn = (mn < b) ? mn : b;
			d = mx - mn;
			sum = mx + mn;
			hue = 0;
			sat = 0;
			if (d != 0) begin
				den = (sum <= 255) ? sum : 510 - sum;
				if (den != 0)
					sat = (2 * 4095 * d + den) / (2 * den);
				if (sat > 4095)
					sat = 4095;
				if (mx == r) begin
					k = 0;
					n = g - b;
				end else if (mx == g) begin
					k = 2;
					n = b - r;
				end else begin
					k = 4;
					n = r - g;
				end
				num = int'(rth_pkg::HUE_SECTOR_Q6) * (k * d + n);
				if (num < 0)
					num += int'(rth_pkg::HUE_FULL_Q6) * d;
				hue = num / d;
				if (hue >= int'(rth_pkg::HUE_FULL_Q6))
					hue = int'(rth_pkg::HUE_FULL_Q6) - 1;
			end
			res.hue_q6         = hue[rth_pkg::HUE_W-1:0];
			res.saturation_q12 = sat[rth_pkg::SAT_W-1:0];
			res.lightness_sum  = sum[rth_pkg::SUM_W-1:0];
			res.achromatic     = (d == 0);
			return res;
		endfunction

		function void note_pixel(rth_pkg::rgb_t px);
			expected_q.push_back(convert(px));
		endfunction

		function void check_word(rth_pkg::hsl_t got);
			rth_pkg::hsl_t exp_w;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected word hue %0d sat %0d sum %0d grey %0b",
					$time, got.hue_q6, got.saturation_q12, got.lightness_sum,
					got.achromatic);
				return;
			end
			exp_w = expected_q.pop_front();
			if (got.hue_q6 !== exp_w.hue_q6 || got.saturation_q12 !== exp_w.saturation_q12 ||
			    got.lightness_sum !== exp_w.lightness_sum ||
			    got.achromatic !== exp_w.achromatic) begin
				errors++;
				$display({"%0t: mismatch exp hue %0d sat %0d sum %0d grey %0b,",
					" got hue %0d sat %0d sum %0d grey %0b"},
					$time, exp_w.hue_q6, exp_w.saturation_q12, exp_w.lightness_sum,
					exp_w.achromatic, got.hue_q6, got.saturation_q12, got.lightness_sum,
					got.achromatic);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	int unsigned cycle_cnt;
	int          src_idle;
	int          snk_idle;

	rth_rgb_if pix_if();
	rth_hsl_if hsl_if();

	hsl_scoreboard sb = new();

	rgb_to_hsl dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_if),
		.hsl_out (hsl_if)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial cycle_cnt = 0;
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	initial begin
		wait (cycle_cnt == CYCLE_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	initial hsl_if.ready = 1'b0;
	always @(posedge clk) begin
		hsl_if.ready <= ($urandom_range(99) >= snk_idle);
	end

	always @(posedge clk) begin
		if (pix_if.valid && pix_if.ready)
			sb.note_pixel(pix_if.data);
		if (hsl_if.valid && hsl_if.ready)
			sb.check_word(hsl_if.data);
	end

	task automatic send(rth_pkg::rgb_t px);
		while ($urandom_range(99) < src_idle) begin
			pix_if.valid <= 1'b0;
			@(posedge clk);
		end
		pix_if.valid <= 1'b1;
		pix_if.data  <= px;
		@(posedge clk);
		while (!pix_if.ready)
			@(posedge clk);
	endtask

	function automatic logic [7:0] near(int v);
		int c;
		c = v + int'($urandom_range(2)) - 1;
		return c[7:0];
	endfunction

	function automatic logic [7:0] corner();
		return $urandom_range(1) ? 8'd255 - 8'($urandom_range(1)) : 8'($urandom_range(1));
	endfunction

	function automatic rth_pkg::rgb_t rand_pixel();
		rth_pkg::rgb_t px;
		logic [7:0] m, o;
		int v;
		px = rth_pkg::rgb_t'($urandom);
		case ($urandom_range(9))
			0: begin
				px.green = px.red;
				px.blue  = px.red;
			end
			1: begin
				m = 8'($urandom_range(255));
				o = 8'($urandom_range(m));
				case ($urandom_range(2))
					0: px = '{red: m, green: m, blue: o};
					1: px = '{red: m, green: o, blue: m};
					default: px = '{red: o, green: m, blue: m};
				endcase
			end
			2: begin
				px.red   = corner();
				px.green = corner();
				px.blue  = corner();
			end
			3: begin
				v = $urandom_range(1, 254);
				px = '{red: near(v), green: near(v), blue: near(v)};
			end
			default: ;
		endcase
		return px;
	endfunction

	initial begin
		arst_n       = 1'b0;
		pix_if.valid = 1'b0;
		pix_if.data  = '0;
		src_idle     = 15;
		snk_idle     = 55;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// greys, primaries, ties, hue wrap, lightness fold at 255
		send(rth_pkg::rgb_t'{8'd0, 8'd0, 8'd0});
		send(rth_pkg::rgb_t'{8'd255, 8'd255, 8'd255});
		send(rth_pkg::rgb_t'{8'd128, 8'd128, 8'd128});
		send(rth_pkg::rgb_t'{8'd255, 8'd0, 8'd0});
		send(rth_pkg::rgb_t'{8'd0, 8'd255, 8'd0});
		send(rth_pkg::rgb_t'{8'd0, 8'd0, 8'd255});
		send(rth_pkg::rgb_t'{8'd255, 8'd255, 8'd0});
		send(rth_pkg::rgb_t'{8'd0, 8'd255, 8'd255});
		send(rth_pkg::rgb_t'{8'd255, 8'd0, 8'd255});
		send(rth_pkg::rgb_t'{8'd255, 8'd0, 8'd1});
		send(rth_pkg::rgb_t'{8'd255, 8'd1, 8'd0});
		send(rth_pkg::rgb_t'{8'd1, 8'd0, 8'd0});
		send(rth_pkg::rgb_t'{8'd0, 8'd1, 8'd1});
		send(rth_pkg::rgb_t'{8'd255, 8'd255, 8'd254});
		send(rth_pkg::rgb_t'{8'd254, 8'd255, 8'd255});
		send(rth_pkg::rgb_t'{8'd255, 8'd1, 8'd1});
		send(rth_pkg::rgb_t'{8'd128, 8'd127, 8'd127});
		send(rth_pkg::rgb_t'{8'd127, 8'd128, 8'd128});
		send(rth_pkg::rgb_t'{8'd1, 8'd2, 8'd0});
		send(rth_pkg::rgb_t'{8'd170, 8'd85, 8'd255});
		send(rth_pkg::rgb_t'{8'd200, 8'd100, 8'd56});

		// hold off until the pipeline is empty
		pix_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);

		repeat (700) send(rand_pixel());
		src_idle = 55;
		snk_idle = 15;
		repeat (700) send(rand_pixel());
		src_idle = 0;
		snk_idle = 0;
		repeat (500) send(rand_pixel());

		pix_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
